FILE: rtl/core/execute_argument_list_parser_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the execute argument list parser RTL.
// ---------------------------------------------------------------------------
`ifndef EXECUTE_ARGUMENT_LIST_PARSER_ASSERT_SVH
`define EXECUTE_ARGUMENT_LIST_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define EAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define EAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/eal_pkg.sv
// ---------------------------------------------------------------------------
// eal_pkg
// Types, character constants and helpers for the argument list parser.
// ---------------------------------------------------------------------------
`default_nettype none

package eal_pkg;

  localparam int unsigned OUT_DEPTH = 3;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    PH_ARG          = 3'd0,
    PH_AFTER_DIGIT  = 3'd1,
    PH_EXPECT_QUOTE = 3'd2,
    PH_VALUE        = 3'd3,
    PH_AFTER_VALUE  = 3'd4,
    PH_END          = 3'd5,
    PH_ERROR        = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_ARG     = 3'd1,
    EV_ARG_VAL = 3'd2,
    EV_BYTE    = 3'd3,
    EV_DONE    = 3'd4,
    EV_END     = 3'd5,
    EV_ERROR   = 3'd6
  } event_t;

  typedef struct packed {
    event_t      ev;
    logic [3:0]  arg;
    logic [7:0]  byte_val;
    logic        last;
  } result_t;

  // What one accepted item pushes into the result queue.
  typedef struct packed {
    logic    push;
    logic    two;
    result_t r0;
    result_t r1;
  } push_t;

  function automatic logic is_value_char(input logic [7:0] b);
    is_value_char = (b == CH_BANG)
                 || (b >= 8'h23 && b <= 8'h26)
                 || (b >= 8'h28 && b <= 8'h5B)
                 || (b >= 8'h5D && b <= 8'h7E);
  endfunction

  function automatic result_t mk_result(input event_t ev, input logic [3:0] arg,
                                        input logic [7:0] b, input logic last);
    result_t r;
    r.ev       = ev;
    r.arg      = arg;
    r.byte_val = b;
    r.last     = last;
    mk_result  = r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/eal_parse_fsm.sv
// ---------------------------------------------------------------------------
// eal_parse_fsm
// Phase register and per-byte decode; emits one or two results per item.
// ---------------------------------------------------------------------------
`default_nettype none

module eal_parse_fsm
  import eal_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_input,
  input  wire logic       first_of_message,
  output push_t           push_o
);

  phase_t     phase_r, phase_nxt;
  logic [3:0] digit_r, digit_nxt;

  phase_t     cur;
  logic [3:0] cur_digit;
  logic       eom;
  logic       is_digit;

  // A new message restarts the parse before this byte is looked at.
  assign cur       = first_of_message ? PH_ARG : phase_r;
  assign cur_digit = first_of_message ? 4'd0 : digit_r;
  assign eom       = end_of_input || (data_byte == CH_NUL);
  assign is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);

  // next state
  always_comb begin
    phase_nxt = PH_ERROR;
    digit_nxt = cur_digit;
    unique case (cur)
      PH_ARG: begin
        if (eom) begin
          phase_nxt = PH_END;
        end else if (is_digit) begin
          phase_nxt = PH_AFTER_DIGIT;
          digit_nxt = data_byte[3:0];
        end
      end
      PH_AFTER_DIGIT: begin
        if (eom) begin
          phase_nxt = PH_END;
        end else if (data_byte == CH_COMMA) begin
          phase_nxt = PH_ARG;
        end else if (data_byte == CH_EQUAL) begin
          phase_nxt = PH_EXPECT_QUOTE;
        end
      end
      PH_EXPECT_QUOTE: begin
        if (!eom && data_byte == CH_QUOTE) phase_nxt = PH_VALUE;
      end
      PH_VALUE: begin
        if (!eom && is_value_char(data_byte)) begin
          phase_nxt = PH_VALUE;
        end else if (!eom && data_byte == CH_QUOTE) begin
          phase_nxt = PH_AFTER_VALUE;
        end
      end
      PH_AFTER_VALUE: begin
        if (eom) begin
          phase_nxt = PH_END;
        end else if (data_byte == CH_COMMA) begin
          phase_nxt = PH_ARG;
        end
      end
      PH_END:   phase_nxt = PH_END;
      default:  phase_nxt = PH_ERROR;
    endcase
  end

  // outputs
  always_comb begin
    push_o.push = accept;
    push_o.two  = 1'b0;
    push_o.r0   = mk_result(EV_ERROR, 4'd0, 8'd0, 1'b1);
    push_o.r1   = mk_result(EV_END, 4'd0, 8'd0, 1'b1);
    unique case (cur)
      PH_ARG: begin
        if (eom) begin
          push_o.r0 = mk_result(EV_END, 4'd0, 8'd0, 1'b1);
        end else if (is_digit) begin
          push_o.r0 = mk_result(EV_NONE, 4'd0, 8'd0, 1'b1);
        end
      end
      PH_AFTER_DIGIT: begin
        if (eom) begin
          push_o.two = 1'b1;
          push_o.r0  = mk_result(EV_ARG, cur_digit, 8'd0, 1'b0);
        end else if (data_byte == CH_COMMA) begin
          push_o.r0 = mk_result(EV_ARG, cur_digit, 8'd0, 1'b1);
        end else if (data_byte == CH_EQUAL) begin
          push_o.r0 = mk_result(EV_NONE, 4'd0, 8'd0, 1'b1);
        end
      end
      PH_EXPECT_QUOTE: begin
        if (!eom && data_byte == CH_QUOTE) begin
          push_o.r0 = mk_result(EV_ARG_VAL, cur_digit, 8'd0, 1'b1);
        end
      end
      PH_VALUE: begin
        if (!eom && is_value_char(data_byte)) begin
          push_o.r0 = mk_result(EV_BYTE, 4'd0, data_byte, 1'b1);
        end else if (!eom && data_byte == CH_QUOTE) begin
          push_o.r0 = mk_result(EV_NONE, 4'd0, 8'd0, 1'b1);
        end
      end
      PH_AFTER_VALUE: begin
        if (eom) begin
          push_o.two = 1'b1;
          push_o.r0  = mk_result(EV_DONE, 4'd0, 8'd0, 1'b0);
        end else if (data_byte == CH_COMMA) begin
          push_o.r0 = mk_result(EV_DONE, 4'd0, 8'd0, 1'b1);
        end
      end
      PH_END:  push_o.r0 = mk_result(EV_END, 4'd0, 8'd0, 1'b1);
      default: push_o.r0 = mk_result(EV_ERROR, 4'd0, 8'd0, 1'b1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ARG;
      digit_r <= 4'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      digit_r <= digit_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/eal_out_queue.sv
// ---------------------------------------------------------------------------
// eal_out_queue
// Shifting result queue; takes up to two results a cycle, gives one.
// ---------------------------------------------------------------------------
`default_nettype none

`include "execute_argument_list_parser_assert.svh"

module eal_out_queue
  import eal_pkg::*;
#(
  parameter int unsigned DEPTH = OUT_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push_i,
  output logic       has_room,
  output logic       out_valid,
  input  wire logic  out_ready,
  output result_t    head
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  result_t         ent_r [DEPTH];
  result_t         ent_nxt [DEPTH];
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   base;
  logic            pop;
  logic            pair;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign head      = ent_r[0];
  // Room for a two-result item, regardless of what leaves this cycle.
  assign has_room  = (cnt_r <= CW'(DEPTH - 2));
  assign base      = cnt_r - CW'(pop);
  assign pair      = push_i.push && push_i.two;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (pop && (i + 1 < DEPTH)) ent_nxt[i] = ent_r[(i + 1) % DEPTH];
      else                        ent_nxt[i] = ent_r[i];
      if (push_i.push && CW'(i) == base) ent_nxt[i] = push_i.r0;
      if (push_i.push && push_i.two && CW'(i) == base + CW'(1)) ent_nxt[i] = push_i.r1;
    end
    cnt_nxt = base + CW'(push_i.push) + CW'(push_i.push && push_i.two);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) ent_r[i] <= ent_nxt[i];
  end

  `EAL_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(DEPTH), "queue count over depth")
  `EAL_ASSERT_NOW(a_push_room, push_i.push, has_room, "push without room")
  `EAL_ASSERT_NOW(a_pair_last, pair, push_i.r1.last && !push_i.r0.last, "bad last flags on pair")
  `EAL_ASSERT_NEXT(a_pop_drain, pop && !push_i.push, cnt_r == $past(cnt_r) - CW'(1), "pop did not drain")

endmodule

`default_nettype wire

FILE: rtl/core/execute_argument_list_parser.sv
// ---------------------------------------------------------------------------
// execute_argument_list_parser
// Byte-wise parser for a comma separated list of single-digit arguments
// with optional ='text' values.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one message byte per item, or an
// end-of-message marker; in_first_of_message restarts the parse.
// Result channel (out_valid/out_ready): one result per item, two when an
// argument or value is closed by end of message; out_last_of_run marks the
// final result of an item.
// The results of an item are written into the result queue on accept.
// Throughput: one item per cycle while the receiver takes results and each
// item gives one result; an item with two results gives them one after the
// other. The decode is a single pass from the phase register into a small
// result queue. in_ready is high while the queue has room for two results,
// so the next item is taken while earlier results still wait.
// Reset: the parser expects an argument digit and the queue is empty.
// Receiver stall: results stay queued and in_ready drops once fewer than
// two queue slots are free.
// ---------------------------------------------------------------------------
`default_nettype none

module execute_argument_list_parser
  import eal_pkg::*;
#(
  parameter int unsigned DEPTH = OUT_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_input,
  input  wire logic       in_first_of_message,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_event_res,
  output logic [3:0]      out_arg_number,
  output logic [7:0]      out_value_byte,
  output logic            out_last_of_run
);

  push_t   push;
  result_t head;

  eal_parse_fsm u_fsm (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (in_valid && in_ready),
    .data_byte        (in_data_byte),
    .end_of_input     (in_end_of_input),
    .first_of_message (in_first_of_message),
    .push_o           (push)
  );

  eal_out_queue #(.DEPTH(DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (push),
    .has_room  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_event_res   = head.ev;
  assign out_arg_number  = head.arg;
  assign out_value_byte  = head.byte_val;
  assign out_last_of_run = head.last;

endmodule

`default_nettype wire

FILE: verif/tb_execute_argument_list_parser.sv
// ---------------------------------------------------------------------------
// tb_execute_argument_list_parser
// Self-checking testbench for the execute argument list parser. Directed
// messages cover the corner cases. Random well-formed argument lists, some
// of them corrupted, and raw noise follow. An in-bench parser model predicts
// every result. Both handshakes idle and stall at random.
// ---------------------------------------------------------------------------
module tb_execute_argument_list_parser
  import eal_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct packed {
    event_t     ev;
    logic [3:0] arg;
    logic [7:0] val;
    logic       last;
  } parse_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
    logic       first;
  } msg_item_t;

  typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_end_of_input = 1'b0;
  logic       in_first_of_message = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_event_res;
  logic [3:0] out_arg_number;
  logic [7:0] out_value_byte;
  logic       out_last_of_run;

  // parser model state
  phase_t     model_phase = PH_ARG;
  logic [3:0] model_digit = 4'd0;

  parse_result_t expected_results[$];
  int unsigned   fail_count = 0;
  int unsigned   items_sent = 0;
  int unsigned   cycle_count = 0;
  int unsigned   burst_left = 0;
  rx_mode_t      rx_mode = RX_ALWAYS;
  int unsigned   rx_tick = 0;
  int unsigned   rx_hold = 0;

  execute_argument_list_parser u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_end_of_input     (in_end_of_input),
    .in_first_of_message (in_first_of_message),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_event_res       (out_event_res),
    .out_arg_number      (out_arg_number),
    .out_value_byte      (out_value_byte),
    .out_last_of_run     (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic value_char_ok(input logic [7:0] b);
    return (b == CH_BANG) || (b >= 8'h23 && b <= 8'h26) ||
           (b >= 8'h28 && b <= 8'h5B) || (b >= 8'h5D && b <= 8'h7E);
  endfunction

  function automatic logic [7:0] random_value_char();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h21, 8'h7E)); while (!value_char_ok(b));
    return b;
  endfunction

  function automatic msg_item_t msg_byte(input logic [7:0] b);
    msg_item_t m;
    m.data  = b;
    m.eoi   = 1'b0;
    m.first = 1'b0;
    return m;
  endfunction

  // Advances the parser model by one item and queues the results it causes.
  task automatic predict_parse(input logic [7:0] b, input logic eoi, input logic first);
    logic          eom;
    logic          two;
    parse_result_t r;
    eom = eoi || (b == CH_NUL);
    two = 1'b0;
    r   = '{ev: EV_ERROR, arg: 4'd0, val: 8'd0, last: 1'b0};
    if (first) begin
      model_phase = PH_ARG;
      model_digit = 4'd0;
    end
    case (model_phase)
      PH_ARG: begin
        if (eom) begin
          r.ev = EV_END;
          model_phase = PH_END;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
          model_digit = b[3:0];
          r.ev = EV_NONE;
          model_phase = PH_AFTER_DIGIT;
        end else begin
          model_phase = PH_ERROR;
        end
      end
      PH_AFTER_DIGIT: begin
        if (eom) begin
          r.ev  = EV_ARG;
          r.arg = model_digit;
          two   = 1'b1;
          model_phase = PH_END;
        end else if (b == CH_COMMA) begin
          r.ev  = EV_ARG;
          r.arg = model_digit;
          model_phase = PH_ARG;
        end else if (b == CH_EQUAL) begin
          r.ev = EV_NONE;
          model_phase = PH_EXPECT_QUOTE;
        end else begin
          model_phase = PH_ERROR;
        end
      end
      PH_EXPECT_QUOTE: begin
        if (!eom && b == CH_QUOTE) begin
          r.ev  = EV_ARG_VAL;
          r.arg = model_digit;
          model_phase = PH_VALUE;
        end else begin
          model_phase = PH_ERROR;
        end
      end
      PH_VALUE: begin
        if (!eom && value_char_ok(b)) begin
          r.ev  = EV_BYTE;
          r.val = b;
        end else if (!eom && b == CH_QUOTE) begin
          r.ev = EV_NONE;
          model_phase = PH_AFTER_VALUE;
        end else begin
          model_phase = PH_ERROR;
        end
      end
      PH_AFTER_VALUE: begin
        if (eom) begin
          r.ev = EV_DONE;
          two  = 1'b1;
          model_phase = PH_END;
        end else if (b == CH_COMMA) begin
          r.ev = EV_DONE;
          model_phase = PH_ARG;
        end else begin
          model_phase = PH_ERROR;
        end
      end
      PH_END: r.ev = EV_END;
      default: model_phase = PH_ERROR;
    endcase
    if (two) begin
      expected_results.push_back(r);
      r = '{ev: EV_END, arg: 4'd0, val: 8'd0, last: 1'b0};
    end
    r.last = 1'b1;
    expected_results.push_back(r);
  endtask

  // Sender: bursts of random length separated by random gaps.
  task automatic send_item(input logic [7:0] b, input logic eoi, input logic first);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid            <= 1'b1;
    in_data_byte        <= b;
    in_end_of_input     <= eoi;
    in_first_of_message <= first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_parse(b, eoi, first);
    items_sent++;
  endtask

  // Receiver: out_ready pattern that switches among four random styles.
  always @(posedge clk) begin
    rx_tick++;
    if (rx_tick % 97 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) rx_hold = $urandom_range(1, 8);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    parse_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: event_res=%0d arg_number=%0d value_byte=%02h",
               out_event_res, out_arg_number, out_value_byte);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_event_res !== want.ev) begin
          $error("event_res: expected %0d, got %0d", want.ev, out_event_res);
          fail_count++;
        end
        if (out_arg_number !== want.arg) begin
          $error("arg_number: expected %0d, got %0d", want.arg, out_arg_number);
          fail_count++;
        end
        if (out_value_byte !== want.val) begin
          $error("value_byte: expected %02h, got %02h", want.val, out_value_byte);
          fail_count++;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, out_last_of_run);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed_cases();
    send_item(8'h41, 1'b1, 1'b1);               // empty message, data ignored
    send_item("x", 1'b0, 1'b0);                 // end sticks
    send_item(CH_ZERO + 8'd9, 1'b0, 1'b1);
    send_item(CH_EQUAL, 1'b0, 1'b0);
    send_item(CH_QUOTE, 1'b0, 1'b0);
    send_item(CH_BANG, 1'b0, 1'b0);
    send_item(8'h7E, 1'b0, 1'b0);
    send_item(CH_QUOTE, 1'b0, 1'b0);
    send_item(CH_COMMA, 1'b0, 1'b0);
    send_item(CH_ZERO, 1'b0, 1'b0);
    send_item(CH_COMMA, 1'b0, 1'b0);
    send_item("5", 1'b0, 1'b0);
    send_item(CH_NUL, 1'b0, 1'b0);              // arg closed by NUL: two results
    send_item("3", 1'b0, 1'b1);
    send_item(CH_EQUAL, 1'b0, 1'b0);
    send_item(CH_QUOTE, 1'b0, 1'b0);
    send_item(8'h5C, 1'b0, 1'b0);               // backslash not allowed in value
    send_item(8'hFF, 1'b0, 1'b0);               // error sticks
    send_item(8'hFF, 1'b0, 1'b1);               // bad first byte
    send_item("7", 1'b0, 1'b1);
    send_item(CH_COMMA, 1'b0, 1'b0);
    send_item(8'h41, 1'b1, 1'b0);               // trailing comma then end
    send_item("1", 1'b0, 1'b1);
    send_item(CH_EQUAL, 1'b0, 1'b0);
    send_item(CH_QUOTE, 1'b0, 1'b0);
    send_item(CH_QUOTE, 1'b0, 1'b0);            // empty value
    send_item(8'h00, 1'b1, 1'b0);
  endtask

  // Mostly well-formed argument lists; some get one item corrupted.
  task automatic test_random_messages(input int unsigned item_goal);
    msg_item_t   msg[$];
    msg_item_t   m;
    int unsigned nargs;
    int unsigned vlen;
    int unsigned idx;
    while (items_sent < item_goal) begin
      msg.delete();
      nargs = $urandom_range(0, 4);
      for (int a = 0; a < nargs; a++) begin
        if (a > 0) msg.push_back(msg_byte(CH_COMMA));
        msg.push_back(msg_byte(CH_ZERO + 8'($urandom_range(0, 9))));
        if ($urandom_range(0, 1)) begin
          msg.push_back(msg_byte(CH_EQUAL));
          msg.push_back(msg_byte(CH_QUOTE));
          vlen = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 5);
          repeat (vlen) msg.push_back(msg_byte(random_value_char()));
          msg.push_back(msg_byte(CH_QUOTE));
        end
      end
      if (nargs > 0 && $urandom_range(0, 5) == 0) msg.push_back(msg_byte(CH_COMMA));
      m = msg_byte(CH_NUL);
      if ($urandom_range(0, 1)) begin
        m.data = 8'($urandom_range(0, 255));
        m.eoi  = 1'b1;
      end
      msg.push_back(m);
      msg[0].first = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        idx = $urandom_range(0, msg.size() - 1);
        case ($urandom_range(0, 3))
          0: msg[idx] = msg_byte(8'($urandom_range(0, 255)));
          1: msg[idx].eoi = 1'b1;
          2: msg[idx].first = 1'b1;                 // restart mid message
          default: msg = msg[0:idx];                // cut short
        endcase
      end
      // items after the end or an error must repeat the sticky event
      repeat ($urandom_range(0, 2)) begin
        m = msg_byte(8'($urandom_range(0, 255)));
        m.eoi = 1'($urandom_range(0, 1));
        msg.push_back(m);
      end
      foreach (msg[i]) send_item(msg[i].data, msg[i].eoi, msg[i].first);
    end
  endtask

  task automatic test_noise(input int unsigned count);
    repeat (count) begin
      send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0),
                ($urandom_range(0, 5) == 0));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_messages(1130);
    test_noise(150);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
